[sv/clipped_alpha_rect_fill_macros.svh]
// Assertion macros for the clipped alpha rectangle fill block.
// Used by clipped_alpha_rect_fill.sv; expects clk and rst in scope.
`ifndef CLIPPED_ALPHA_RECT_FILL_MACROS_SVH
`define CLIPPED_ALPHA_RECT_FILL_MACROS_SVH
`ifndef SYNTHESIS
`define CARF_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CARF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CARF_ASSERT(name, expr, msg)
`define CARF_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

[sv/carf_pkg.sv]
// Shared types, constants and the divide-by-255 helper for the rectangle fill block.
// No dependencies.
`timescale 1ns / 1ps

package carf_pkg;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_t;

  localparam int unsigned COORD_W      = 12;
  localparam int unsigned CW           = COORD_W + 2;  // room for x + w - 1
  localparam int unsigned STRIDE_W     = 9;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd128;
  localparam int unsigned STORE_DEPTH  = 16384;
  localparam int unsigned MAW          = 14;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef logic [31:0] pixel_t;

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

[sv/carf_if.sv]
// Handshake channel interfaces: draw/read requests, pixel responses, stride config.
// Depends on carf_pkg.
`timescale 1ns / 1ps

interface carf_req_if;
  logic                             valid;
  logic                             ready;
  carf_pkg::op_t                    op;
  logic signed [carf_pkg::COORD_W-1:0] pos_x;
  logic signed [carf_pkg::COORD_W-1:0] pos_y;
  logic signed [carf_pkg::COORD_W-1:0] rect_width;
  logic signed [carf_pkg::COORD_W-1:0] rect_height;
  logic [31:0]                      colour;

  modport source (output valid, op, pos_x, pos_y, rect_width, rect_height, colour,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, rect_width, rect_height, colour,
                  output ready);
endinterface

interface carf_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        in_range;

  modport source (output valid, pixel, in_range, input ready);
  modport sink   (input valid, pixel, in_range, output ready);
endinterface

interface carf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [carf_pkg::STRIDE_W-1:0]     row_stride;

  modport source (output valid, row_stride, input ready);
  modport sink   (input valid, row_stride, output ready);
endinterface

[sv/clipped_alpha_rect_fill.sv]
// Clipped, alpha-blended rectangle fill over a 16384 x 32-bit frame store.
// Depends on carf_pkg, carf_if.sv and clipped_alpha_rect_fill_macros.svh.
//
// After reset the block zeroes the frame store, one pixel a cycle, in the S_CLEAR sweep;
// no request is taken during that sweep, stride writes are. A draw request passes S_SETUP
// and S_BASE, then issues one pixel per cycle unless a hazard stalls it, set by the
// single read-modify-write pass over the store (read, blend, write back in a three-stage
// pipe), drains the pipe and returns to S_IDLE, which takes the next request; a draw that
// clips to nothing issues no pixel. When rows overlap in the store (stride below the
// rectangle width) a pixel whose address is still in flight stalls issue until that
// write has landed. A read request passes S_SETUP, S_BASE, S_RDADDR and S_RDOUT to its
// response; a new request is taken while the response still waits in the output
// register.
`timescale 1ns / 1ps
`include "clipped_alpha_rect_fill_macros.svh"

module clipped_alpha_rect_fill #(
  parameter int unsigned FRAME_WIDTH  = 128,
  parameter int unsigned FRAME_HEIGHT = 64
) (
  input  logic           clk,
  input  logic           rst,
  carf_req_if.sink       req,
  carf_rsp_if.source     rsp,
  carf_cfg_if.sink       cfg
);
  import carf_pkg::*;

  localparam int unsigned XW  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int unsigned YW  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int unsigned BW  = YW + STRIDE_W;
  localparam int unsigned AW0 = (BW > XW) ? BW : XW;
  localparam int unsigned AW  = ((AW0 > MAW) ? AW0 : MAW) + 1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_BASE   = 7'b0001000,
    S_DRAW   = 7'b0010000,
    S_RDADDR = 7'b0100000,
    S_RDOUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // frame store
  pixel_t   mem [STORE_DEPTH];
  pixel_t   rdata;
  logic     mem_re, mem_we;
  logic [MAW-1:0] mem_raddr, mem_waddr;
  pixel_t   mem_wdata;

  logic [STRIDE_W-1:0] row_stride;
  logic [MAW-1:0]      clr_cnt;

  // captured request
  op_t                     op_q;
  logic signed [CW-1:0]    xs, ys, ws, hs;
  pixel_t                  colour_q;
  logic [7:0]              alpha;

  // clipped bounds
  logic [XW-1:0] x0, x_end, col;
  logic [YW-1:0] y0, y_end, row;
  logic          empty, in_frame, active;
  logic [AW-1:0] row_base, addr_a;
  logic          ok_a, hazard, issue;

  // pipe stages
  logic          vb, vc, ok_b, ok_c;
  logic [AW-1:0] addr_b, addr_c;
  logic [15:0]   sum_c [3];
  pixel_t        blend_px;

  // read response
  logic   rd_hit, out_valid, out_load, out_in_range;
  pixel_t out_pixel;

  // clip arithmetic
  logic signed [CW-1:0] sx, sy, ex_raw, ey_raw, ex, ey;
  logic signed [CW-1:0] fw_m1, fh_m1, fw_s, fh_s;

  assign fw_m1 = $signed(CW'(FRAME_WIDTH - 1));
  assign fh_m1 = $signed(CW'(FRAME_HEIGHT - 1));
  assign fw_s  = $signed(CW'(FRAME_WIDTH));
  assign fh_s  = $signed(CW'(FRAME_HEIGHT));

  always_comb begin
    sx     = xs[CW-1] ? '0 : xs;
    sy     = ys[CW-1] ? '0 : ys;
    ex_raw = xs + ws - $signed(CW'(1));
    ey_raw = ys + hs - $signed(CW'(1));
    ex     = (ex_raw > fw_m1) ? fw_m1 : ex_raw;
    ey     = (ey_raw > fh_m1) ? fh_m1 : ey_raw;
  end

  assign alpha  = colour_q[31:24];
  assign addr_a = row_base + AW'(col);
  assign ok_a   = addr_a < AW'(STORE_DEPTH);
  // a pixel still in the pipe must land before its address is read again
  assign hazard = (vb && addr_b == addr_a) || (vc && addr_c == addr_a);
  assign issue  = (state == S_DRAW) && active && !hazard;
  assign out_load = (state == S_RDOUT) && (!out_valid || rsp.ready);

  assign req.ready    = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign rsp.valid    = out_valid;
  assign rsp.pixel    = out_pixel;
  assign rsp.in_range = out_in_range;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_cnt == MAW'(STORE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:   if (req.valid) state_next = S_SETUP;
      S_SETUP:  state_next = S_BASE;
      S_BASE:   state_next = (op_q == OP_READ) ? S_RDADDR : S_DRAW;
      S_DRAW:   if (!active && !vb && !vc) state_next = S_IDLE;
      S_RDADDR: state_next = S_RDOUT;
      S_RDOUT:  if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + MAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= STRIDE_RESET;
    end else if (cfg.valid) begin
      row_stride <= cfg.row_stride;
    end
  end

  // request capture and clipping
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q     <= req.op;
      xs       <= CW'(req.pos_x);
      ys       <= CW'(req.pos_y);
      ws       <= CW'(req.rect_width);
      hs       <= CW'(req.rect_height);
      colour_q <= req.colour;
    end
    if (state == S_SETUP) begin
      if (op_q == OP_READ) begin
        x0 <= xs[XW-1:0];
        y0 <= ys[YW-1:0];
      end else begin
        x0 <= sx[XW-1:0];
        y0 <= sy[YW-1:0];
      end
      x_end    <= ex[XW-1:0];
      y_end    <= ey[YW-1:0];
      empty    <= (ex < sx) || (ey < sy);
      in_frame <= !xs[CW-1] && (xs < fw_s) && !ys[CW-1] && (ys < fh_s);
    end
  end

  // pixel walker
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (state == S_BASE) begin
      active <= (op_q == OP_DRAW) && !empty;
    end else if (issue && col == x_end && row == y_end) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BASE) begin
      row_base <= AW'(y0) * AW'(row_stride);
      col      <= x0;
      row      <= y0;
    end else if (issue) begin
      if (col == x_end) begin
        col      <= x0;
        row      <= row + YW'(1);
        row_base <= row_base + AW'(row_stride);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  // read-modify-write pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      vb <= issue;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    addr_b <= addr_a;
    ok_b   <= ok_a;
    addr_c <= addr_b;
    ok_c   <= ok_b;
    for (int i = 0; i < 3; i++) begin
      sum_c[i] <= 16'(colour_q[8*i +: 8]) * 16'(alpha)
                + 16'(rdata[8*i +: 8]) * 16'(8'hFF - alpha);
    end
  end

  assign blend_px = (alpha == ALPHA_OPAQUE) ? colour_q
                  : {ALPHA_OPAQUE, div255(sum_c[2]), div255(sum_c[1]), div255(sum_c[0])};

  // store ports
  always_comb begin
    mem_re    = issue && ok_a;
    mem_raddr = addr_a[MAW-1:0];
    if (state == S_RDADDR) begin
      mem_re = in_frame && ok_a;
    end
    mem_we    = vc && ok_c;
    mem_waddr = addr_c[MAW-1:0];
    mem_wdata = blend_px;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // read response
  always_ff @(posedge clk) begin
    if (state == S_RDADDR) rd_hit <= in_frame && ok_a;
    if (out_load) begin
      out_pixel    <= rd_hit ? rdata : '0;
      out_in_range <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  `CARF_ASSERT(a_no_inflight_alias, !(vb && vc && addr_b == addr_c), "in-flight alias")
  `CARF_ASSERT_IMPL(a_we_owner, mem_we, state == S_CLEAR || state == S_DRAW, "stray write")
  `CARF_ASSERT_IMPL(a_accept_drained, req.valid && req.ready, !vb && !vc && !active, "pipe busy")
  `CARF_ASSERT_IMPL(a_miss_zero, out_valid && !out_in_range, out_pixel == '0, "miss not zero")

endmodule
